// ===== rtl/swk_pkg.sv =====
// Shared types, widths and the arctangent table for the swerve wheel kinematics block.
package swk_pkg;

  localparam int XW           = 29;  // wheel component, signed Q.24
  localparam int SW           = 58;  // square of a component magnitude
  localparam int NW           = 59;  // sum of squares and root accumulator
  localparam int CW           = 32;  // CORDIC x and y
  localparam int ZW           = 23;  // CORDIC angle accumulator, Q.20
  localparam int SQ_STEPS     = 30;
  localparam int CORDIC_STEPS = 21;

  typedef enum logic [1:0] {
    REG_SINGLE_MODE = 2'd0,
    REG_HALF_LENGTH = 2'd1,
    REG_HALF_WIDTH  = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] lf_speed;
    logic signed [15:0] lf_angle;
    logic signed [15:0] lb_speed;
    logic signed [15:0] lb_angle;
    logic signed [15:0] rb_speed;
    logic signed [15:0] rb_angle;
    logic signed [15:0] rf_speed;
    logic signed [15:0] rf_angle;
  } wheel_cmd_t;

  typedef struct packed {
    logic [NW-1:0]        n;
    logic [NW-1:0]        res;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 neg;
    logic                 zero;
  } wheel_t;

  typedef struct packed {
    logic               single;
    logic signed [15:0] vel_x;
    logic signed [15:0] yaw_rate;
    wheel_t [3:0]       wh;
  } work_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = ZW'(823550);
      1:       r = ZW'(486170);
      2:       r = ZW'(256879);
      3:       r = ZW'(130396);
      4:       r = ZW'(65451);
      5:       r = ZW'(32757);
      6:       r = ZW'(16383);
      default: r = (i < CORDIC_STEPS) ? ZW'(1) <<< (20 - i) : ZW'(0);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/swk_front.sv =====
// Front: yaw products, wheel components, squares, sums and CORDIC start values.
module swk_front import swk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  cmd_t        cmd,
  input  logic        single_mode,
  input  logic [11:0] half_length,
  input  logic [11:0] half_width,
  output logic        out_valid,
  output work_t       work
);

  logic                 v1, v2, v3;
  logic                 single1, single2, single3;
  logic signed [15:0]   vx1, vy1, w1, vx2, w2, vx3, w3;
  logic signed [XW-1:0] wx1, wy1;
  logic signed [XW-1:0] lx, rx, fy, ky;
  logic [SW-1:0]        sq_x [2];
  logic [SW-1:0]        sq_y [2];
  wheel_t [3:0]         wh3;
  wheel_t [3:0]         wh3_next;
  wheel_t [3:0]         work_wh_next;
  logic signed [XW-1:0] xs [4];
  logic signed [XW-1:0] ys [4];
  logic [XW-1:0]        ax_l, ax_r, ay_f, ay_k;

  // Wheel order: left front, left back, right back, right front.
  always_comb begin
    xs[0] = lx; ys[0] = fy;
    xs[1] = lx; ys[1] = ky;
    xs[2] = rx; ys[2] = ky;
    xs[3] = rx; ys[3] = fy;
    ax_l = lx[XW-1] ? XW'(-lx) : XW'(lx);
    ax_r = rx[XW-1] ? XW'(-rx) : XW'(rx);
    ay_f = fy[XW-1] ? XW'(-fy) : XW'(fy);
    ay_k = ky[XW-1] ? XW'(-ky) : XW'(ky);
    for (int k = 0; k < 4; k++) begin
      wh3_next[k].n    = '0;
      wh3_next[k].res  = '0;
      wh3_next[k].z    = '0;
      wh3_next[k].neg  = xs[k][XW-1];
      wh3_next[k].zero = (xs[k] == '0) && (ys[k] == '0);
      wh3_next[k].cx   = xs[k][XW-1] ? -CW'(xs[k]) : CW'(xs[k]);
      wh3_next[k].cy   = xs[k][XW-1] ? -CW'(ys[k]) : CW'(ys[k]);
    end
  end

  // Sum of squares joins the CORDIC start values.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      work_wh_next[k]   = wh3[k];
      work_wh_next[k].n = NW'(sq_x[k / 2]) + NW'(sq_y[(k == 0 || k == 3) ? 0 : 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      single1 <= single_mode;
      vx1 <= cmd.vel_x;
      vy1 <= cmd.vel_y;
      w1  <= cmd.yaw_rate;
      wx1 <= XW'(cmd.yaw_rate) * XW'($signed({1'b0, half_width}));
      wy1 <= XW'(cmd.yaw_rate) * XW'($signed({1'b0, half_length}));
      single2 <= single1;
      vx2 <= vx1;
      w2  <= w1;
      lx  <= XW'($signed({vx1, 12'd0})) - wx1;
      rx  <= XW'($signed({vx1, 12'd0})) + wx1;
      fy  <= XW'($signed({vy1, 12'd0})) + wy1;
      ky  <= XW'($signed({vy1, 12'd0})) - wy1;
      single3 <= single2;
      vx3 <= vx2;
      w3  <= w2;
      sq_x[0] <= SW'(ax_l) * SW'(ax_l);
      sq_x[1] <= SW'(ax_r) * SW'(ax_r);
      sq_y[0] <= SW'(ay_f) * SW'(ay_f);
      sq_y[1] <= SW'(ay_k) * SW'(ay_k);
      wh3 <= wh3_next;
      work.single   <= single3;
      work.vel_x    <= vx3;
      work.yaw_rate <= w3;
      work.wh       <= work_wh_next;
    end
  end

endmodule

// ===== rtl/swk_step.sv =====
// One pipeline step: one root bit for each wheel, and one CORDIC rotation while K < CORDIC_STEPS.
module swk_step import swk_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  work_t in_work,
  output logic  out_valid,
  output work_t out_work
);

  localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQ_STEPS - 1 - K));

  work_t nxt;

  always_comb begin
    nxt = in_work;
    for (int k = 0; k < 4; k++) begin
      if (in_work.wh[k].n >= in_work.wh[k].res + BIT) begin
        nxt.wh[k].n   = in_work.wh[k].n - (in_work.wh[k].res + BIT);
        nxt.wh[k].res = (in_work.wh[k].res >> 1) + BIT;
      end else begin
        nxt.wh[k].res = in_work.wh[k].res >> 1;
      end
      if (K < CORDIC_STEPS) begin
        if (!in_work.wh[k].cy[CW-1]) begin
          nxt.wh[k].cx = in_work.wh[k].cx + (in_work.wh[k].cy >>> K);
          nxt.wh[k].cy = in_work.wh[k].cy - (in_work.wh[k].cx >>> K);
          nxt.wh[k].z  = in_work.wh[k].z + atan_entry(K);
        end else begin
          nxt.wh[k].cx = in_work.wh[k].cx - (in_work.wh[k].cy >>> K);
          nxt.wh[k].cy = in_work.wh[k].cy + (in_work.wh[k].cx >>> K);
          nxt.wh[k].z  = in_work.wh[k].z - atan_entry(K);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_work <= nxt;
    end
  end

endmodule

// ===== rtl/swk_back.sv =====
// Last stage: round, saturate and sign speeds and angles into the output word.
module swk_back import swk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  work_t      work,
  output logic       out_valid,
  output wheel_cmd_t result
);

  logic [15:0]          sp [4];
  logic [15:0]          an [4];
  logic [NW-1:0]        m;
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   w2;
  logic [15:0]          w_ang;
  wheel_cmd_t           res_next;

  always_comb begin
    w2    = {work.yaw_rate, 1'b0};
    w_ang = (w2 > 17'sd32767) ? 16'h7fff : (w2 < -17'sd32768) ? 16'h8000 : w2[15:0];
    m  = '0;
    zr = '0;
    for (int k = 0; k < 4; k++) begin
      m  = (work.wh[k].res + NW'(2048)) >> 12;
      zr = (work.wh[k].z + ZW'(64)) >>> 7;
      if (work.wh[k].neg) begin
        sp[k] = (m > NW'(32768)) ? 16'h8000 : 16'(-m[15:0]);
      end else begin
        sp[k] = (m > NW'(32767)) ? 16'h7fff : m[15:0];
      end
      an[k] = (zr > ZW'(32767)) ? 16'h7fff : (zr < -ZW'(32768)) ? 16'h8000 : zr[15:0];
      if (work.wh[k].zero) begin
        sp[k] = '0;
        an[k] = '0;
      end
      if (work.single) begin
        sp[k] = work.vel_x;
        an[k] = w_ang;
      end
    end
    res_next.lf_speed = sp[0]; res_next.lf_angle = an[0];
    res_next.lb_speed = sp[1]; res_next.lb_angle = an[1];
    res_next.rb_speed = sp[2]; res_next.rb_angle = an[2];
    res_next.rf_speed = sp[3]; res_next.rf_angle = an[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/swerve_wheel_kinematics.sv =====
// Top level of the swerve wheel kinematics pipeline.
//
// Input channel in_valid/in_stall/in_data carries one body velocity word
// (vel_x, vel_y, yaw_rate, signed Q3.12). Output channel out_valid/out_stall/
// out_data carries one word per command: signed speed (Q3.12) and steering
// angle (Q2.13 rad) for left front, left back, right back and right front.
// A word moves at a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (single mode, half length, half width); write only while idle.
// Depth: four front stages (products, components, squares,
// sum of squares), thirty root/CORDIC steps and one output stage. The
// thirty-stage root pipeline, one result bit per stage, sets the depth.
// Throughput is one word per cycle unless a held output word stalls; every
// stage is registered and moves as one, so commands enter while results flow out.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the register defaults
// (single mode off, half length 1098, half width 651).
module swerve_wheel_kinematics import swk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output wheel_cmd_t out_data,
  input  logic       cfg_we,
  input  cfg_reg_t   cfg_index,
  input  logic [11:0] cfg_data
);

  logic        single_mode;
  logic [11:0] half_length;
  logic [11:0] half_width;
  logic        adv;
  logic        v_pipe [SQ_STEPS + 1];
  work_t       w_pipe [SQ_STEPS + 1];

  // Advance everywhere unless a finished word is held at the output.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_mode <= 1'b0;
      half_length <= 12'd1098;
      half_width  <= 12'd651;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SINGLE_MODE: single_mode <= cfg_data[0];
        REG_HALF_LENGTH: half_length <= cfg_data;
        REG_HALF_WIDTH:  half_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  swk_front u_front (
    .clk, .rst, .adv,
    .in_valid    (in_valid),
    .cmd         (in_data),
    .single_mode (single_mode),
    .half_length (half_length),
    .half_width  (half_width),
    .out_valid   (v_pipe[0]),
    .work        (w_pipe[0])
  );

  // Root bit per stage; CORDIC rotation only while g < CORDIC_STEPS (steps 0 to 20).
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    swk_step #(.K(g)) u_step (
      .clk, .rst, .adv,
      .in_valid  (v_pipe[g]),
      .in_work   (w_pipe[g]),
      .out_valid (v_pipe[g + 1]),
      .out_work  (w_pipe[g + 1])
    );
  end

  swk_back u_back (
    .clk, .rst, .adv,
    .in_valid  (v_pipe[SQ_STEPS]),
    .work      (w_pipe[SQ_STEPS]),
    .out_valid (out_valid),
    .result    (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output word valid straight after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("waiting output word lost under stall");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");
  a_last_step_follows: assert property (@(posedge clk) disable iff (rst)
    adv && v_pipe[SQ_STEPS] |=> out_valid)
    else $error("word from last step did not reach output");

endmodule
